/* rtl/core/hsdu_pkg.sv */
package hsdu_pkg;

    // Table geometry
    localparam int INDEX_BITS  = 16;
    localparam int TABLE_DEPTH = 1 << INDEX_BITS;

    // Datapath widths
    localparam int WGT_W  = 32;           // Q8.24 weight, feature and scale words
    localparam int SUM_W  = 48;           // Q24.24 running sum and result
    localparam int MUL_W  = 33;           // signed operand width of the shared multiplier
    localparam int PROD_W = 2 * MUL_W;    // registered product width
    localparam int FRAC_W = 24;           // fraction bits dropped by the product shift (w_prod_sh)
    localparam int ACC_W  = PROD_W - FRAC_W;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [WGT_W-1:0] WGT_MAX = {1'b0, {(WGT_W-1){1'b1}}};
    localparam logic [WGT_W-1:0] WGT_MIN = {1'b1, {(WGT_W-1){1'b0}}};

    // Request modes
    localparam logic [1:0] MODE_ACCUM  = 2'd0;
    localparam logic [1:0] MODE_UPDATE = 2'd1;
    localparam logic [1:0] MODE_WRITE  = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_INDEX_MASK = 2'd0;
    localparam logic [1:0] CFG_DECAY      = 2'd1;
    localparam logic [1:0] CFG_QUAD_MULT  = 2'd2;

    // Configuration reset values
    localparam logic [15:0] RST_INDEX_MASK = 16'hFFFF;
    localparam logic [24:0] RST_DECAY      = 25'h100_0000;
    localparam logic [31:0] RST_QUAD_MULT  = 32'd27942141;

    // Result kinds
    localparam logic KIND_PREDICT = 1'b0;
    localparam logic KIND_WEIGHT  = 1'b1;

    // Weight table access from the sequencer
    typedef struct packed {
        logic                  we;
        logic [INDEX_BITS-1:0] waddr;
        logic [WGT_W-1:0]      wdata;
        logic                  re;
        logic [INDEX_BITS-1:0] raddr;
    } t_tab_req;

endpackage

/* rtl/core/hsdu_mul.sv */
module hsdu_mul (
    input  logic                                i_clk,
    input  logic signed [hsdu_pkg::MUL_W-1:0]  i_a,
    input  logic signed [hsdu_pkg::MUL_W-1:0]  i_b,
    output logic signed [hsdu_pkg::PROD_W-1:0] o_prod
);
    import hsdu_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // Shared signed multiplier, product registered every cycle
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

/* rtl/core/hsdu_wtab.sv */
module hsdu_wtab (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hsdu_pkg::t_tab_req           i_req,
    output logic [hsdu_pkg::WGT_W-1:0]   o_rdata,
    output logic                         o_clr_busy
);
    import hsdu_pkg::*;

    logic [WGT_W-1:0]      r_mem [TABLE_DEPTH];
    logic [WGT_W-1:0]      r_rdata;
    logic [INDEX_BITS-1:0] r_clr_addr;
    logic                  r_clr_busy;

    // Clearing sweep after reset, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (&r_clr_addr) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clr_busy = r_clr_busy;

endmodule

/* rtl/core/hashed_sparse_dot_and_update_core.sv */
// Channel  | Handshake                 | Payload
// ---------+---------------------------+------------------------------------------
// in       | i_in_valid / o_in_stall   | i_mode .. i_last, one sparse feature
// out      | o_out_valid / i_out_stall | o_result_value, o_result_kind
// cfg      | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
// One request at a time through a single shared 33x33 multiplier and one weight
// table. All modes run S_HASH to S_EXEC; writes stop there, reads go to S_OUT,
// the others to S_ADD1; update writes back via S_MUL2, S_ADD2; accumulate with
// last scales via S_MUL2 to S_ADD3, then S_OUT. The result waits in an output
// register, so the next request is taken while it is stalled; a further result
// holds the sequencer until that register frees. After reset the table is swept
// to zero with o_in_stall high; configuration writes are taken during the sweep.
module hashed_sparse_dot_and_update_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_feature_index,
    input  logic signed [31:0] i_feature_value,
    input  logic [31:0] i_cross_index,
    input  logic        i_cross_enable,
    input  logic [31:0] i_index_offset,
    input  logic signed [31:0] i_scale,
    input  logic signed [31:0] i_write_data,
    input  logic        i_last,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [47:0] o_result_value,
    output logic        o_result_kind
);
    import hsdu_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_HASH = 4'd1;
    localparam logic [3:0] S_ADDR = 4'd2;
    localparam logic [3:0] S_READ = 4'd3;
    localparam logic [3:0] S_EXEC = 4'd4;
    localparam logic [3:0] S_ADD1 = 4'd5;
    localparam logic [3:0] S_MUL2 = 4'd6;
    localparam logic [3:0] S_ADD2 = 4'd7;
    localparam logic [3:0] S_MUL3 = 4'd8;
    localparam logic [3:0] S_ADD3 = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0] r_state, n_state;

    // Configuration registers
    logic [15:0] r_index_mask;
    logic [24:0] r_decay;
    logic [31:0] r_quad;

    // Latched request
    logic [1:0]        r_mode;
    logic [31:0]       r_feat;
    logic [WGT_W-1:0]  r_x;
    logic [31:0]       r_cross;
    logic              r_cross_en;
    logic [31:0]       r_offset;
    logic [WGT_W-1:0]  r_sc;
    logic [WGT_W-1:0]  r_wdata;
    logic              r_last;

    // Datapath state
    logic [INDEX_BITS-1:0] r_addr;
    logic [SUM_W-1:0]      r_sum;
    logic [ACC_W-1:0]      r_acc;
    logic [SUM_W-1:0]      r_res;
    logic                  r_res_kind;
    logic                  r_out_valid;
    logic [SUM_W-1:0]      r_out_value;
    logic                  r_out_kind;

    logic                     w_in_acc;
    logic                     w_out_load;
    logic                     w_clr_busy;
    logic [WGT_W-1:0]         w_w;
    t_tab_req                 w_req;
    logic signed [MUL_W-1:0]  w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic [ACC_W-1:0]         w_prod_sh;
    logic [31:0]              w_hash_sum;
    logic [31:0]              w_mask_ext;
    logic [SUM_W:0]           w_sum_ext;
    logic [SUM_W-1:0]         w_sum_sat;
    logic [ACC_W:0]           w_nw_ext;
    logic [WGT_W-1:0]         w_nw_sat;
    logic [57:0]              w_scl_ext;
    logic [SUM_W-1:0]         w_scl_sat;

    assign o_in_stall = (r_state != S_IDLE) || w_clr_busy;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_mask <= RST_INDEX_MASK;
            r_decay      <= RST_DECAY;
            r_quad       <= RST_QUAD_MULT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INDEX_MASK: r_index_mask <= i_cfg_data[15:0];
                CFG_DECAY:      r_decay      <= i_cfg_data[24:0];
                CFG_QUAD_MULT:  r_quad       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mode     <= i_mode;
            r_feat     <= i_feature_index;
            r_x        <= i_feature_value;
            r_cross    <= i_cross_index;
            r_cross_en <= i_cross_enable;
            r_offset   <= i_index_offset;
            r_sc       <= i_scale;
            r_wdata    <= i_write_data;
            r_last     <= i_last;
        end
    end

    // Shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_HASH: begin
                w_mul_a = {1'b0, r_quad};
                w_mul_b = {1'b0, r_cross};
            end
            S_EXEC: begin
                if (r_mode == MODE_UPDATE) begin
                    w_mul_a = {r_x[WGT_W-1], r_x};
                    w_mul_b = {r_sc[WGT_W-1], r_sc};
                end else begin
                    w_mul_a = {w_w[WGT_W-1], w_w};
                    w_mul_b = {r_x[WGT_W-1], r_x};
                end
            end
            S_MUL2: begin
                if (r_mode == MODE_UPDATE) begin
                    w_mul_a = {8'b0, r_decay};
                    w_mul_b = {w_w[WGT_W-1], w_w};
                end else begin
                    w_mul_a = {9'b0, r_sum[FRAC_W-1:0]};
                    w_mul_b = {r_sc[WGT_W-1], r_sc};
                end
            end
            S_MUL3: begin
                w_mul_a = {{9{r_sum[SUM_W-1]}}, r_sum[SUM_W-1:FRAC_W]};
                w_mul_b = {r_sc[WGT_W-1], r_sc};
            end
            default: ;
        endcase
    end

    hsdu_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Floor of product / 2^24
    assign w_prod_sh = w_prod[PROD_W-1:FRAC_W];

    // Hashed address, masked to the table
    assign w_hash_sum = r_feat + r_offset + (r_cross_en ? w_prod[31:0] : 32'd0);
    assign w_mask_ext = {16'b0, r_index_mask};

    // Running sum accumulate with saturation
    assign w_sum_ext = {r_sum[SUM_W-1], r_sum}
                     + {{(SUM_W + 1 - ACC_W){w_prod_sh[ACC_W-1]}}, w_prod_sh};
    assign w_sum_sat = (w_sum_ext[SUM_W] != w_sum_ext[SUM_W-1])
                     ? (w_sum_ext[SUM_W] ? SUM_MIN : SUM_MAX) : w_sum_ext[SUM_W-1:0];

    // Decayed weight update with saturation to 32 bits
    assign w_nw_ext = {w_prod_sh[ACC_W-1], w_prod_sh} + {r_acc[ACC_W-1], r_acc};
    assign w_nw_sat = (w_nw_ext[ACC_W:WGT_W-1] != {(ACC_W - WGT_W + 2){w_nw_ext[ACC_W]}})
                    ? (w_nw_ext[ACC_W] ? WGT_MIN : WGT_MAX) : w_nw_ext[WGT_W-1:0];

    // Scaled prediction: high part of sum times scale plus low part times scale
    assign w_scl_ext = w_prod[57:0] + {{(58 - ACC_W){r_acc[ACC_W-1]}}, r_acc};
    assign w_scl_sat = (w_scl_ext[57:SUM_W-1] != {(59 - SUM_W){w_scl_ext[57]}})
                     ? (w_scl_ext[57] ? SUM_MIN : SUM_MAX) : w_scl_ext[SUM_W-1:0];

    // Weight table access
    always_comb begin
        w_req.re    = (r_state == S_READ);
        w_req.raddr = r_addr;
        w_req.we    = ((r_state == S_EXEC) && (r_mode == MODE_WRITE))
                   || ((r_state == S_ADD2) && (r_mode == MODE_UPDATE));
        w_req.waddr = r_addr;
        w_req.wdata = (r_mode == MODE_WRITE) ? r_wdata : w_nw_sat;
    end

    hsdu_wtab u_wtab (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .o_rdata    (w_w),
        .o_clr_busy (w_clr_busy)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_in_acc) n_state = S_HASH;
            S_HASH: n_state = S_ADDR;
            S_ADDR: n_state = S_READ;
            S_READ: n_state = S_EXEC;
            S_EXEC: begin
                case (r_mode)
                    MODE_ACCUM, MODE_UPDATE: n_state = S_ADD1;
                    MODE_WRITE:              n_state = S_IDLE;
                    default:                 n_state = S_OUT;
                endcase
            end
            S_ADD1: begin
                if (r_mode == MODE_UPDATE || r_last) begin
                    n_state = S_MUL2;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MUL2: n_state = S_ADD2;
            S_ADD2: n_state = (r_mode == MODE_UPDATE) ? S_IDLE : S_MUL3;
            S_MUL3: n_state = S_ADD3;
            S_ADD3: n_state = S_OUT;
            S_OUT:  if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (r_state == S_ADD1 && r_mode == MODE_ACCUM) begin
            r_sum <= w_sum_sat;
        end else if (r_state == S_ADD3) begin
            r_sum <= '0;
        end
    end

    // Address, partial product and result registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_ADDR: r_addr <= w_hash_sum[INDEX_BITS-1:0] & w_mask_ext[INDEX_BITS-1:0];
            S_EXEC: begin
                r_res      <= {{(SUM_W - WGT_W){w_w[WGT_W-1]}}, w_w};
                r_res_kind <= KIND_WEIGHT;
            end
            S_ADD1: r_acc <= w_prod_sh;
            S_ADD2: r_acc <= w_prod_sh;
            S_ADD3: begin
                r_res      <= w_scl_sat;
                r_res_kind <= KIND_PREDICT;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_value <= r_res;
            r_out_kind  <= r_res_kind;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_result_kind  = r_out_kind;

    // Checks
    a_clear_holds_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_busy |-> (o_in_stall && !w_req.we))
        else $error("table written or request taken during clearing sweep");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_HASH))
        else $error("accepted request did not start hashing");

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD3) |=> (r_sum == '0))
        else $error("running sum not cleared after prediction");

    a_kind_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (o_out_valid && (o_result_kind == $past(r_mode == MODE_READ))))
        else $error("result kind does not match request mode");

endmodule
